>>> rtl/grr_pkg.sv
// ----------------------------------------------------------------------------
// grr_pkg
// Shared constants, types and helpers for the group reverse reorder block.
// ----------------------------------------------------------------------------
package grr_pkg;

    localparam int MAX_GROUP   = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int CFG_W       = 5;
    localparam int IDX_W       = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int COUNT_W     = $clog2(MAX_GROUP + 1);
    localparam int NUM_BANKS   = 2;
    localparam int BANK_W      = 1;
    localparam int ADDR_W      = BANK_W + IDX_W;
    localparam int MEM_DEPTH   = NUM_BANKS * (1 << IDX_W);

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    typedef struct packed {
        logic [BANK_W-1:0]  bank;
        logic [COUNT_W-1:0] count;
        logic               reverse;
        logic               last;
    } grr_desc_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        data_t             data;
    } grr_wr_t;

    function automatic logic [COUNT_W-1:0] grr_eff_size(input logic [CFG_W-1:0] gs);
        if (gs == '0) begin
            return COUNT_W'(1);
        end
        if (int'(gs) > MAX_GROUP) begin
            return COUNT_W'(MAX_GROUP);
        end
        return COUNT_W'(gs);
    endfunction

endpackage

>>> rtl/group_reverse_reorder.sv
// ----------------------------------------------------------------------------
// group_reverse_reorder
// Reverse a stream in groups of the configured size; emit a short tail as is.
// ----------------------------------------------------------------------------
// Path: group descriptor queue, then read register, then output register.
// Throughput: one beat per cycle in and out while m_ready holds; two group banks
// overlap fill and drain; input stalls only while both hold undrained groups.
// Reset: group size returns to 1, fill count, queue and output stages clear;
// bank contents are left as they are.
// ----------------------------------------------------------------------------
module group_reverse_reorder (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [grr_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  grr_pkg::data_t             s_item_value,
    input  logic                       s_item_last,
    output logic                       m_valid,
    input  logic                       m_ready,
    output grr_pkg::data_t             m_out_value,
    output logic                       m_out_last
);
    import grr_pkg::*;

    logic      push;
    logic      pop;
    logic      q_full;
    logic      q_valid;
    grr_desc_t push_desc;
    grr_desc_t q_head;
    grr_wr_t   wr;

    assign cfg_ready = 1'b1;

    grr_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item_value (s_item_value),
        .s_item_last  (s_item_last),
        .q_full       (q_full),
        .push         (push),
        .push_desc    (push_desc),
        .wr           (wr)
    );

    grr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .full      (q_full),
        .valid     (q_valid),
        .head      (q_head)
    );

    grr_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr          (wr),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_value (m_out_value),
        .m_out_last  (m_out_last)
    );

endmodule

>>> rtl/grr_front.sv
// ----------------------------------------------------------------------------
// grr_front
// Accept items, write them into the current group bank and close groups.
// ----------------------------------------------------------------------------
module grr_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    input  logic [grr_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  grr_pkg::data_t             s_item_value,
    input  logic                       s_item_last,
    input  logic                       q_full,
    output logic                       push,
    output grr_pkg::grr_desc_t         push_desc,
    output grr_pkg::grr_wr_t           wr
);
    import grr_pkg::*;

    logic [CFG_W-1:0]   group_size_reg;
    logic [IDX_W-1:0]   fill_reg;
    logic [IDX_W-1:0]   fill_next;
    logic [BANK_W-1:0]  bank_reg;
    logic [BANK_W-1:0]  bank_next;
    logic [COUNT_W-1:0] k;
    logic [COUNT_W-1:0] n;
    logic               accept;
    logic               full_group;

    always_comb begin
        k          = grr_eff_size(group_size_reg);
        n          = COUNT_W'(fill_reg) + COUNT_W'(1);
        s_ready    = !q_full;
        accept     = s_valid && s_ready;
        full_group = (n >= k);
        push       = accept && (full_group || s_item_last);

        push_desc.bank    = bank_reg;
        push_desc.count   = n;
        push_desc.reverse = full_group;
        push_desc.last    = s_item_last;

        wr.en   = accept;
        wr.addr = {bank_reg, fill_reg};
        wr.data = s_item_value;

        fill_next = fill_reg;
        bank_next = bank_reg;
        if (push) begin
            fill_next = '0;
            bank_next = ~bank_reg;
        end else if (accept) begin
            fill_next = IDX_W'(n);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_size_reg <= CFG_W'(1);
            fill_reg       <= '0;
            bank_reg       <= '0;
        end else begin
            if (cfg_valid) begin
                group_size_reg <= cfg_data;
            end
            fill_reg <= fill_next;
            bank_reg <= bank_next;
        end
    end

    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_item_last |-> push)
        else $error("last item did not close its group");

    a_push_clears_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> fill_reg == '0)
        else $error("fill count not cleared after group close");

endmodule

>>> rtl/grr_queue.sv
// ----------------------------------------------------------------------------
// grr_queue
// Two-entry descriptor queue between the front and the back, one per bank.
// ----------------------------------------------------------------------------
module grr_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  grr_pkg::grr_desc_t  push_desc,
    input  logic                pop,
    output logic                full,
    output logic                valid,
    output grr_pkg::grr_desc_t  head
);
    import grr_pkg::*;

    grr_desc_t  entry_reg [NUM_BANKS];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    always_comb begin
        full  = (cnt_reg == 2'd2);
        valid = (cnt_reg != 2'd0);
        head  = entry_reg[rd_ptr_reg];
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full) && !(pop && !valid))
        else $error("descriptor queue overflow or underflow");

endmodule

>>> rtl/grr_back.sv
// ----------------------------------------------------------------------------
// grr_back
// Hold the group banks and drain each closed group in forward or reverse order.
// ----------------------------------------------------------------------------
module grr_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  grr_pkg::grr_wr_t    wr,
    input  logic                q_valid,
    input  grr_pkg::grr_desc_t  q_head,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output grr_pkg::data_t      m_out_value,
    output logic                m_out_last
);
    import grr_pkg::*;

    data_t              mem [MEM_DEPTH];
    data_t              rd_data_reg;
    logic               rd_last_reg;
    logic               rd_valid_reg;
    data_t              o_data_reg;
    logic               o_last_reg;
    logic               o_valid_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic [COUNT_W-1:0] top;
    logic [IDX_W-1:0]   offset;
    logic               move;
    logic               issue;
    logic               end_item;

    always_comb begin
        top      = q_head.count - COUNT_W'(1);
        move     = rd_valid_reg && (!o_valid_reg || m_ready);
        issue    = q_valid && (!rd_valid_reg || move);
        end_item = (idx_reg == IDX_W'(top));
        pop      = issue && end_item;
        offset   = q_head.reverse ? IDX_W'(top - COUNT_W'(idx_reg)) : idx_reg;
        idx_next = idx_reg;
        if (pop) begin
            idx_next = '0;
        end else if (issue) begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (issue) begin
            rd_data_reg <= mem[{q_head.bank, offset}];
            rd_last_reg <= q_head.last && end_item;
        end
        if (move) begin
            o_data_reg <= rd_data_reg;
            o_last_reg <= rd_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end else begin
            idx_reg      <= idx_next;
            rd_valid_reg <= issue || (rd_valid_reg && !move);
            o_valid_reg  <= move || (o_valid_reg && !m_ready);
        end
    end

    assign m_valid     = o_valid_reg;
    assign m_out_value = o_data_reg;
    assign m_out_last  = o_last_reg;

    a_rd_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg && !move |=> rd_valid_reg && $stable(rd_data_reg))
        else $error("read stage lost a beat under stall");

endmodule

>>> tb/sv/group_reverse_reorder_tb.sv
// ----------------------------------------------------------------------------
// group_reverse_reorder_tb
// Streams signed lists through the group reverser under random group sizes,
// sender bursts and receiver stalls, predicts every output beat in a small
// scoreboard and checks value and end flag of each beat in order.
// ----------------------------------------------------------------------------
module group_reverse_reorder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import grr_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 75;
    localparam int SHOW_LIMIT    = 10;

    typedef struct {
        data_t value;
        logic  last;
    } beat_t;

    class reorder_scoreboard;
        logic [CFG_W-1:0] size_reg = CFG_W'(1);
        data_t            held[MAX_GROUP];
        int               fill = 0;
        beat_t            reorder_q[$];
        int               errors = 0;
        int               shown = 0;
        int               items = 0;
        int               results = 0;
        int               rev_groups = 0;
        int               tails = 0;

        function int group_span();
            if (size_reg == '0) begin
                return 1;
            end
            if (int'(size_reg) > MAX_GROUP) begin
                return MAX_GROUP;
            end
            return int'(size_reg);
        endfunction

        function void set_size(logic [CFG_W-1:0] d);
            size_reg = d;
        endfunction

        function void take_item(data_t v, logic l);
            int    k;
            int    n;
            beat_t b;
            k = group_span();
            if (fill >= MAX_GROUP) begin
                fill = 0;
            end
            held[fill] = v;
            fill++;
            n = fill;
            items++;
            if (n >= k) begin
                for (int i = 0; i < n; i++) begin
                    b.value = held[n-1-i];
                    b.last  = l && (i == n - 1);
                    reorder_q.push_back(b);
                end
                fill = 0;
                rev_groups++;
            end else if (l) begin
                for (int i = 0; i < n; i++) begin
                    b.value = held[i];
                    b.last  = (i == n - 1);
                    reorder_q.push_back(b);
                end
                fill = 0;
                tails++;
            end
        endfunction

        function void flag(string msg);
            if (shown < SHOW_LIMIT) begin
                $display("%s", msg);
                shown++;
            end
            errors++;
        endfunction

        function void match_beat(data_t v, logic l);
            beat_t b;
            results++;
            if (reorder_q.size() == 0) begin
                flag($sformatf("output beat %0d unexpected: value %h last %b",
                               results, v, l));
                return;
            end
            b = reorder_q.pop_front();
            if (v !== b.value) begin
                flag($sformatf("output beat %0d value: expected %h, got %h",
                               results, b.value, v));
            end
            if (l !== b.last) begin
                flag($sformatf("output beat %0d last: expected %b, got %b",
                               results, b.last, l));
            end
        endfunction

        function void close_out();
            beat_t b;
            while (reorder_q.size() != 0) begin
                b = reorder_q.pop_front();
                flag($sformatf("missing output beat: value %h last %b", b.value, b.last));
            end
        endfunction
    endclass

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    data_t            s_item_value = '0;
    logic             s_item_last = 1'b0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    data_t            m_out_value;
    logic             m_out_last;

    reorder_scoreboard sb;
    int                cycle_count = 0;
    int                burst_left = 4;
    bit                s_hold = 1'b0;
    int                cfg_writes = 0;
    logic [15:0]       stall_pat = '1;
    int                stall_turn = 0;

    group_reverse_reorder uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item_value (s_item_value),
        .s_item_last  (s_item_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_value  (m_out_value),
        .m_out_last   (m_out_last)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge aclk) begin
        if (stall_turn == 0) begin
            stall_pat  <= ($urandom_range(0, 2) == 0) ? '1 : (16'($urandom) | 16'h0001);
            stall_turn <= 96;
        end else begin
            stall_pat  <= {stall_pat[0], stall_pat[15:1]};
            stall_turn <= stall_turn - 1;
        end
        m_ready <= stall_pat[0];
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.match_beat(m_out_value, m_out_last);
            end
            if (cfg_valid && cfg_ready) begin
                sb.set_size(cfg_data);
            end
            if (s_valid && s_ready) begin
                sb.take_item(s_item_value, s_item_last);
            end
        end
    end

    task automatic send_beat(input data_t v, input logic l);
        s_valid      <= 1'b1;
        s_item_value <= v;
        s_item_last  <= l;
        s_hold = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        if (burst_left <= 0) begin
            s_valid <= 1'b0;
            s_hold = 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 48 : $urandom_range(1, 10);
        end
    endtask

    // hold off until every predicted beat has drained
    task automatic settle();
        if (s_hold) begin
            s_valid <= 1'b0;
            s_hold = 1'b0;
        end
        @(posedge aclk);
        while (sb.reorder_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_size(input logic [CFG_W-1:0] d);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    function automatic data_t pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            default: return data_t'($urandom);
        endcase
    endfunction

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Run stopped by the cycle limit of %0d", CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int               rnd_items;
        int               sel;
        int               span;
        int               lists;
        int               len;
        int               shape;
        logic [CFG_W-1:0] gs;
        logic             l;

        sb = new();
        rnd_items = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        send_beat(32'h7fff_ffff, 1'b0);
        send_beat(32'h8000_0000, 1'b1);

        write_size(CFG_W'(3));
        send_beat('0, 1'b0);
        send_beat('1, 1'b0);
        send_beat(32'h0000_0001, 1'b0);
        send_beat(32'h7fff_ffff, 1'b0);
        send_beat(32'h8000_0000, 1'b1);
        send_beat(32'h0000_000a, 1'b0);
        send_beat(32'hffff_ffec, 1'b0);
        send_beat(32'h0000_001e, 1'b1);

        write_size(CFG_W'(0));
        send_beat(32'hffff_fffb, 1'b1);

        // shrink the group while four items are held
        write_size(CFG_W'(5));
        for (int i = 0; i < 4; i++) begin
            send_beat(pick_value(), 1'b0);
        end
        write_size(CFG_W'(2));
        send_beat(pick_value(), 1'b1);

        write_size(CFG_W'(31));
        for (int i = 0; i < 3; i++) begin
            send_beat(pick_value(), i == 2);
        end

        while (rnd_items < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0:       gs = '0;
                1:       gs = CFG_W'($urandom_range(17, 31));
                2:       gs = CFG_W'(16);
                3:       gs = CFG_W'($urandom_range(7, 15));
                default: gs = CFG_W'($urandom_range(1, 6));
            endcase
            write_size(gs);
            span  = (gs == '0) ? 1 : (int'(gs) > MAX_GROUP) ? MAX_GROUP : int'(gs);
            lists = $urandom_range(1, 3);
            for (int j = 0; j < lists; j++) begin
                len   = $urandom_range(1, 2 * span + 2);
                shape = $urandom_range(0, 5);
                for (int i = 0; i < len; i++) begin
                    if (shape == 0) begin
                        l = ($urandom_range(0, 3) == 0);
                    end else if (shape == 1 && j == lists - 1) begin
                        l = 1'b0;
                    end else begin
                        l = (i == len - 1);
                    end
                    send_beat(pick_value(), l);
                end
                rnd_items += len;
            end
        end

        settle();
        repeat (20) @(posedge aclk);
        sb.close_out();
        $display("Covered %0d input beats and %0d output beats across %0d group size writes.",
                 sb.items, sb.results, cfg_writes);
        $display("%0d groups came out reversed, %0d short tails in arrival order, %0d errors.",
                 sb.rev_groups, sb.tails, sb.errors);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
